// File: sv/kssc_pkg.sv
// Shared types, constants and compare functions for the k-smallest selector.
`timescale 1ns / 1ps

package kssc_pkg;

    localparam int MAX_KEEP = 16;
    localparam int IDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CNT_W    = $clog2(MAX_KEEP + 1);
    localparam int CODE_W   = 32;
    localparam int VAL_W    = 32;
    localparam int SEL_W    = 5;

    typedef struct packed {
        logic [CODE_W-1:0]        code;
        logic signed [VAL_W-1:0]  value;
    } rec_t;

    // controller -> datapath
    typedef struct packed {
        logic insert;
        logic sort_step;
        logic sort_odd;
        logic shift;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
    } stat_t;

    // flip sign bit so an unsigned compare orders two's complement values
    function automatic logic [VAL_W-1:0] ord_key(input logic [VAL_W-1:0] v);
        ord_key = {~v[VAL_W-1], v[VAL_W-2:0]};
    endfunction

    // a ranks strictly after b: value first, then code
    function automatic logic rank_after(input rec_t a, input rec_t b);
        logic [VAL_W-1:0] ka;
        logic [VAL_W-1:0] kb;
        ka = ord_key(a.value);
        kb = ord_key(b.value);
        if (ka != kb)
            rank_after = (ka > kb);
        else
            rank_after = (a.code > b.code);
    endfunction

    // a goes out after b: code first, then value
    function automatic logic emit_after(input rec_t a, input rec_t b);
        if (a.code != b.code)
            emit_after = (a.code > b.code);
        else
            emit_after = (ord_key(a.value) > ord_key(b.value));
    endfunction

endpackage

// File: sv/kssc_dp.sv
// Datapath: limit register, sorted insertion chain, transposition sort, output shift.
`timescale 1ns / 1ps

module kssc_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [kssc_pkg::SEL_W-1:0]    cfg_wr_data,
    input  kssc_pkg::cmd_t                cmd,
    input  kssc_pkg::rec_t                new_rec,
    output kssc_pkg::stat_t               stat,
    output kssc_pkg::rec_t                head_rec
);

    localparam int N = kssc_pkg::MAX_KEEP;
    localparam int CW = kssc_pkg::CNT_W;

    logic [kssc_pkg::SEL_W-1:0] sel_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [CW-1:0]              limit;
    logic [CW-1:0]              count_trim;

    kssc_pkg::rec_t cells_reg  [N];
    kssc_pkg::rec_t cells_next [N];
    kssc_pkg::rec_t ins_val    [N];
    kssc_pkg::rec_t sort_val   [N];
    kssc_pkg::rec_t shift_val  [N];

    logic [N-1:0] gt;
    logic [N-1:0] swap;

    // effective limit: 0 acts as 1, anything above the store depth as full depth
    always_comb
    begin
        if (sel_reg == '0)
            limit = CW'(1);
        else if (32'(sel_reg) > 32'(N))
            limit = CW'(N);
        else
            limit = CW'(sel_reg);
    end

    assign count_trim = (count_reg > limit) ? limit : count_reg;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            // empty slots rank after anything
            assign gt[i] = (CW'(i) >= count_trim) || kssc_pkg::rank_after(cells_reg[i], new_rec);

            if (i == 0)
            begin : g_first
                assign ins_val[i] = gt[i] ? new_rec : cells_reg[i];
            end
            else
            begin : g_rest
                assign ins_val[i] = !gt[i]     ? cells_reg[i] :
                                    !gt[i - 1] ? new_rec      : cells_reg[i - 1];
            end

            if (i < N - 1)
            begin : g_pair
                assign swap[i] = (((i % 2) == 1) == cmd.sort_odd)
                               && (CW'(i + 1) < count_reg)
                               && kssc_pkg::emit_after(cells_reg[i], cells_reg[i + 1]);
                assign shift_val[i] = cells_reg[i + 1];
            end
            else
            begin : g_top
                assign swap[i]      = 1'b0;
                assign shift_val[i] = cells_reg[i];
            end

            if (i == 0)
            begin : g_sort_first
                assign sort_val[i] = swap[i] ? cells_reg[i + ((N > 1) ? 1 : 0)] : cells_reg[i];
            end
            else
            begin : g_sort_rest
                assign sort_val[i] = swap[i]     ? cells_reg[(i < N - 1) ? i + 1 : i] :
                                     swap[i - 1] ? cells_reg[i - 1] : cells_reg[i];
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        for (int j = 0; j < N; j++)
            cells_next[j] = cells_reg[j];
        if (cmd.insert)
        begin
            count_next = (count_trim < limit) ? count_trim + CW'(1) : count_trim;
            for (int j = 0; j < N; j++)
                cells_next[j] = ins_val[j];
        end
        else if (cmd.sort_step)
        begin
            for (int j = 0; j < N; j++)
                cells_next[j] = sort_val[j];
        end
        else if (cmd.shift)
        begin
            count_next = count_reg - CW'(1);
            for (int j = 0; j < N; j++)
                cells_next[j] = shift_val[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= kssc_pkg::SEL_W'(1);
            count_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                sel_reg <= cfg_wr_data;
            count_reg <= count_next;
        end
    end

    // record payload, no reset
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < N; j++)
            cells_reg[j] <= cells_next[j];
    end

    assign stat.count = count_reg;
    assign head_rec   = cells_reg[0];

endmodule

// File: sv/kssc_ctrl.sv
// Controller: collect, sort passes, and emit sequencing.
`timescale 1ns / 1ps

module kssc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             item_last,
    input  logic             out_ready,
    input  kssc_pkg::stat_t  stat,
    output logic             in_ready,
    output logic             out_valid,
    output logic             out_last,
    output kssc_pkg::cmd_t   cmd
);

    localparam int IW = kssc_pkg::IDX_W;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_SORT,
        ST_EMIT
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [IW-1:0] pass_reg;
    logic [IW-1:0] pass_next;
    logic          in_ready_reg;
    logic          in_ready_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          take;
    logic          give;

    assign take = in_valid && in_ready_reg;
    assign give = out_valid_reg && out_ready;

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                pass_next = '0;
                if (take && item_last)
                    state_next = ST_SORT;
            end
            ST_SORT:
            begin
                pass_next = pass_reg + IW'(1);
                if (pass_reg == IW'(kssc_pkg::MAX_KEEP - 1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (give && stat.count == kssc_pkg::CNT_W'(1))
                    state_next = ST_COLLECT;
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
        in_ready_next  = (state_next == ST_COLLECT);
        out_valid_next = (state_next == ST_EMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            pass_reg      <= '0;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready      = in_ready_reg;
    assign out_valid     = out_valid_reg;
    assign out_last      = (stat.count == kssc_pkg::CNT_W'(1));
    assign cmd.insert    = take;
    assign cmd.sort_step = (state_reg == ST_SORT);
    assign cmd.sort_odd  = pass_reg[0];
    assign cmd.shift     = give;

endmodule

// File: sv/k_smallest_sorted_by_code.sv
// Top level of the k-smallest selector with code-ordered output.
`timescale 1ns / 1ps

// Collects a set of (code, value) records and keeps the select_count lowest
// by (value, then code) in a 16-deep insertion chain that stays sorted as
// each record lands. While collecting, in_ready is high and the block takes
// one request per cycle. After the request flagged item_last, the block
// drops in_ready and runs passes of odd-even transposition over the chain
// to reorder the kept records by (code, then value). The kept records then
// leave from the head of the chain, one per accepted output request, with
// out_last on the final one, after which the store is empty and in_ready
// rises again. select_count is taken through cfg_wr_en/cfg_wr_data and
// should only change while the block is idle; 0 acts as 1, values above
// 16 act as 16. Lowering it mid-set trims the store at the next record.
module k_smallest_sorted_by_code
(
    input  logic                              clk,
    input  logic                              rst_n,
    // config
    input  logic                              cfg_wr_en,
    input  logic [kssc_pkg::SEL_W-1:0]        cfg_wr_data,
    // input records
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [kssc_pkg::CODE_W-1:0]       item_code,
    input  logic signed [kssc_pkg::VAL_W-1:0] item_value,
    input  logic                              item_last,
    // output records
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [kssc_pkg::CODE_W-1:0]       out_code,
    output logic signed [kssc_pkg::VAL_W-1:0] out_value,
    output logic                              out_last
);

    kssc_pkg::cmd_t  cmd;
    kssc_pkg::stat_t stat;
    kssc_pkg::rec_t  new_rec;
    kssc_pkg::rec_t  head_rec;

    assign new_rec.code  = item_code;
    assign new_rec.value = item_value;

    // sequencing: collect -> sort passes -> emit
    kssc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .item_last (item_last),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_last  (out_last),
        .cmd       (cmd)
    );

    // record store; its head cell is the output register
    kssc_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .new_rec     (new_rec),
        .stat        (stat),
        .head_rec    (head_rec)
    );

    assign out_code  = head_rec.code;
    assign out_value = head_rec.value;

endmodule

// File: sv/kssc_check.sv
// Port-level checker for the k-smallest selector, bound to the top level.
`timescale 1ns / 1ps

module kssc_check
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              item_last,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [kssc_pkg::CODE_W-1:0]       out_code,
    input logic signed [kssc_pkg::VAL_W-1:0] out_value,
    input logic                              out_last
);

    // a stalled output request holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_code)
                                   && $stable(out_value) && $stable(out_last))
        else $error("output request changed while stalled");

    // no input taken while results are going out
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready during emission");

    // the final record of a set closes the input side
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && item_last |=> !in_ready && !out_valid)
        else $error("input still open after final record");

    // the flagged result ends the emission
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid && in_ready)
        else $error("emission continued after last result");

endmodule

bind k_smallest_sorted_by_code kssc_check u_kssc_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item_last (item_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_code  (out_code),
    .out_value (out_value),
    .out_last  (out_last)
);

// File: sim/tb.sv
// Self-checking testbench for the k-smallest selector with code-ordered output.
`timescale 1ns / 1ps

module tb;

    localparam int KEEP          = kssc_pkg::MAX_KEEP;
    localparam int CW            = kssc_pkg::CODE_W;
    localparam int VW            = kssc_pkg::VAL_W;
    localparam int SW            = kssc_pkg::SEL_W;
    // idle wait covers the sort passes after the last request, with margin on top
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 40;

    // one emitted record as the output side should see it
    typedef struct {
        logic [CW-1:0]        code;
        logic signed [VW-1:0] value;
        logic                 last;
    } emit_rec_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [SW-1:0]        cfg_wr_data = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [CW-1:0]        item_code   = '0;
    logic signed [VW-1:0] item_value  = '0;
    logic                 item_last   = 1'b0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [CW-1:0]        out_code;
    logic signed [VW-1:0] out_value;
    logic                 out_last;

    k_smallest_sorted_by_code dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .item_code   (item_code),
        .item_value  (item_value),
        .item_last   (item_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_code    (out_code),
        .out_value   (out_value),
        .out_last    (out_last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Run limit: ends a hung run with TB_ERROR.
    initial
    begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Selection model: the kept store sorted by rank (value, then code),
    // its fill count, and our copy of select_count.
    // ------------------------------------------------------------------
    logic [CW-1:0]        kept_code  [KEEP];
    logic signed [VW-1:0] kept_value [KEEP];
    int                   kept_num  = 0;
    logic [SW-1:0]        limit_reg = 1;

    // records still owed by the block, oldest first
    emit_rec_t            awaited_q[$];
    int                   err_count = 0;

    // idle rates in percent; recv side is read by the receiver process
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;

    // bumping hold_req asks the receiver for one long hold-off
    int                   hold_req   = 0;
    int                   hold_ack   = 0;
    int                   stall_left = 0;

    // a ranks strictly behind b: larger value, or same value and larger code
    function automatic bit worse_rank(input logic signed [VW-1:0] va,
                                      input logic [CW-1:0] ca,
                                      input logic signed [VW-1:0] vb,
                                      input logic [CW-1:0] cb);
        if (va != vb)
            return va > vb;
        return ca > cb;
    endfunction

    // a leaves after b: larger code, or same code and larger value
    function automatic bit leaves_later(input emit_rec_t a, input emit_rec_t b);
        if (a.code != b.code)
            return a.code > b.code;
        return a.value > b.value;
    endfunction

    // Take one accepted request into the model; on the final record of a set,
    // queue the kept records in code order and empty the store.
    function automatic void absorb_record(input logic [CW-1:0] code,
                                          input logic signed [VW-1:0] value,
                                          input logic last);
        int        k;
        int        pos;
        int        i;
        int        j;
        emit_rec_t ordered [KEEP];
        emit_rec_t r;
        // 0 acts as 1, anything above the store depth acts as the depth
        if (limit_reg == 0)
            k = 1;
        else if (limit_reg > KEEP)
            k = KEEP;
        else
            k = int'(limit_reg);
        // a limit lowered mid-set drops the last-ranked records first
        if (kept_num > k)
            kept_num = k;
        // new record lands behind every kept one it does not beat, so an
        // exact duplicate goes behind the earlier copy
        pos = 0;
        while (pos < kept_num && !worse_rank(kept_value[pos], kept_code[pos], value, code))
            pos++;
        if (pos < k)
        begin
            i = (kept_num < k) ? kept_num : k - 1;
            while (i > pos)
            begin
                kept_code[i]  = kept_code[i - 1];
                kept_value[i] = kept_value[i - 1];
                i--;
            end
            kept_code[pos]  = code;
            kept_value[pos] = value;
            if (kept_num < k)
                kept_num++;
        end
        if (last)
        begin
            for (i = 0; i < kept_num; i++)
            begin
                r.code  = kept_code[i];
                r.value = kept_value[i];
                r.last  = 1'b0;
                j = i;
                while (j > 0 && leaves_later(ordered[j - 1], r))
                begin
                    ordered[j] = ordered[j - 1];
                    j--;
                end
                ordered[j] = r;
            end
            for (i = 0; i < kept_num; i++)
            begin
                ordered[i].last = (i == kept_num - 1);
                awaited_q.push_back(ordered[i]);
            end
            kept_num = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: checks each accepted record against the oldest one owed,
    // then decides out_ready for the next edge.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_result();
        emit_rec_t want;
        if (awaited_q.size() == 0)
        begin
            report_mismatch($sformatf("record with nothing owed: code=%h value=%0d last=%b",
                                      out_code, out_value, out_last));
            return;
        end
        want = awaited_q.pop_front();
        if (out_code !== want.code)
            report_mismatch($sformatf("out_code %h, want %h", out_code, want.code));
        if (out_value !== want.value)
            report_mismatch($sformatf("out_value %0d, want %0d", out_value, want.value));
        if (out_last !== want.last)
            report_mismatch($sformatf("out_last %b, want %b", out_last, want.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result();
            if (hold_req != hold_ack)
            begin
                hold_ack   <= hold_req;
                stall_left <= HOLD_CYCLES;
                out_ready  <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one request and returns at the edge that takes it. Valid stays
    // high on return so a back-to-back request never drops it for a step.
    task automatic send_request(input logic [CW-1:0] code,
                                input logic signed [VW-1:0] value,
                                input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        item_code  <= code;
        item_value <= value;
        item_last  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_record(code, value, last);
    endtask

    // Sender goes quiet until every owed record has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (awaited_q.size() != 0)
            @(posedge clk);
    endtask

    // select_count changes only with the block idle: nothing owed, and time
    // for any sort pass or last insert to finish.
    task automatic set_limit(input logic [SW-1:0] count);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        limit_reg = count;
        cfg_wr_en <= 1'b0;
    endtask

    // codes lean on a few small numbers so that ties are common
    function automatic logic [CW-1:0] pick_code();
        case ($urandom_range(3))
            0: return CW'($urandom_range(7));
            1: return ($urandom_range(1) != 0) ? {CW{1'b1}} : {CW{1'b0}};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(4))
            0: return $signed(VW'($urandom_range(6))) - 3;
            1:
            begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // limit is 1 out of reset; the equal values tie-break on code
    task automatic test_default_limit();
        send_request(32'd5, 32'sd10, 1'b0);
        send_request(32'd2, 32'sd10, 1'b0);
        send_request(32'd9, -32'sd4, 1'b1);
    endtask

    // full-depth limit: extreme codes and values, equal codes, equal values and an
    // exact duplicate
    task automatic test_field_extremes();
        set_limit(SW'(KEEP));
        send_request(32'hffff_ffff, 32'sh7fff_ffff, 1'b0);
        send_request(32'h0000_0000, 32'sh8000_0000, 1'b0);
        send_request(32'h0000_0000, 32'sh7fff_ffff, 1'b0);
        send_request(32'hffff_ffff, 32'sh8000_0000, 1'b0);
        send_request(32'd7, 32'sd0, 1'b0);
        send_request(32'd7, -32'sd1, 1'b0);
        send_request(32'd3, 32'sd5, 1'b0);
        send_request(32'd1, 32'sd5, 1'b0);
        send_request(32'd4, 32'sd4, 1'b0);
        send_request(32'd4, 32'sd4, 1'b1);
    endtask

    // zero acts as one; a limit of three drops records at a tied boundary
    task automatic test_limit_clamp();
        set_limit(0);
        send_request(32'd6, 32'sd3, 1'b0);
        send_request(32'd6, 32'sd2, 1'b1);
        set_limit(3);
        send_request(32'd10, 32'sd1, 1'b0);
        send_request(32'd20, 32'sd0, 1'b0);
        send_request(32'd30, 32'sd0, 1'b0);
        send_request(32'd5, 32'sd1, 1'b0);
        send_request(32'd40, -32'sd9, 1'b1);
    endtask

    // half a set at limit 8, then the limit drops to 2 before the rest
    task automatic test_limit_lowered_midset();
        set_limit(8);
        send_request(32'd100, 32'sd7, 1'b0);
        send_request(32'd101, -32'sd7, 1'b0);
        send_request(32'd102, 32'sd0, 1'b0);
        send_request(32'd103, 32'sd3, 1'b0);
        set_limit(2);
        send_request(32'd104, 32'sd1, 1'b0);
        send_request(32'd105, 32'sd9, 1'b1);
    endtask

    // receiver holds off for a long stretch while two full sets are offered;
    // the block ends up holding in_ready low with a full set waiting
    task automatic test_output_hold();
        int s;
        int i;
        set_limit(SW'(KEEP));
        hold_req <= hold_req + 1;
        for (s = 0; s < 2; s++)
            for (i = 0; i < KEEP; i++)
                send_request(pick_code(), pick_value(), i == KEEP - 1);
    endtask

    // sender stops until the set has fully come out, then starts again
    task automatic test_pause_for_drain();
        int i;
        for (i = 0; i < 12; i++)
            send_request(pick_code(), pick_value(), i == 11);
        drain_results();
        for (i = 0; i < 5; i++)
            send_request(pick_code(), pick_value(), i == 4);
    endtask

    // Random sets of random size, limit changed between some of them.
    // Some records repeat the previous one exactly.
    task automatic run_random_sets(input int n_items);
        int                   sent;
        int                   size;
        int                   i;
        logic [CW-1:0]        c;
        logic signed [VW-1:0] v;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(2) == 0)
            begin
                case ($urandom_range(5))
                    0: set_limit(0);
                    1: set_limit(31);
                    2: set_limit(SW'(KEEP));
                    3: set_limit(1);
                    default: set_limit(SW'($urandom_range(31)));
                endcase
            end
            // mostly small sets; some run past the store depth
            size = ($urandom_range(4) == 0) ? $urandom_range(24, 1) : $urandom_range(10, 1);
            for (i = 0; i < size; i++)
            begin
                if (i == 0 || $urandom_range(7) != 0)
                begin
                    c = pick_code();
                    v = pick_value();
                end
                send_request(c, v, i == size - 1);
            end
            sent += size;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 11;
        recv_idle_pct <= 85;
        test_default_limit();
        test_field_extremes();
        test_limit_clamp();
        test_limit_lowered_midset();
        test_output_hold();
        test_pause_for_drain();
        run_random_sets(80);

        send_idle_pct = 85;
        recv_idle_pct <= 11;
        run_random_sets(80);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_random_sets(80);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
sv/kssc_pkg.sv
sv/kssc_dp.sv
sv/kssc_ctrl.sv
sv/k_smallest_sorted_by_code.sv
sv/kssc_check.sv
sim/tb.sv
